// File: design/srav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srav_pkg;

    localparam int SAMPLE_W = 13;
    localparam int RAILS    = 4;
    localparam int TDATA_W  = 56;
    localparam int CFG_IDX_W = 3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 13'd6553;

    localparam int RAIL_MAIN  = 0;
    localparam int RAIL_FAN   = 1;
    localparam int RAIL_BUCK5 = 2;
    localparam int RAIL_BUCK7 = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAIN_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCK5_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUCK7_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUCK5_ON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUCK7_ON    = 3'd5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [RAILS-1:0] rail_set_t;

    localparam sample_t LIMIT_RESET [RAILS] = '{13'd1050, 13'd2100, 13'd400, 13'd500};

    typedef struct packed {
        logic shift;
        logic fill;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/srav_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module srav_cell (
    input  wire logic                  clk,
    input  wire srav_pkg::cell_ctrl_t  ctrl,
    input  wire srav_pkg::rail_set_t   fill_in,
    input  wire srav_pkg::rail_set_t   next_in,
    output srav_pkg::rail_set_t        cell_out
);

    srav_pkg::rail_set_t cell_reg;
    srav_pkg::rail_set_t cell_next;

    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.shift)
        begin
            cell_next = ctrl.fill ? fill_in : next_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// File: design/srav_div.sv
`timescale 1ns / 1ps
`default_nettype none

module srav_div #(
    parameter int WINDOW_LEN = 10
) (
    input  wire logic                                              clk,
    input  wire logic                                              en,
    input  wire logic [srav_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0]  sum,
    output srav_pkg::sample_t                                      quot
);

    localparam int CLOG_W  = $clog2(WINDOW_LEN);
    localparam int SUM_W   = srav_pkg::SAMPLE_W + CLOG_W;
    localparam int SHIFT   = SUM_W + CLOG_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // Rounded-up reciprocal gives the exact floor for every sum of SUM_W bits.
    always_comb
    begin
        prod_next = prod_reg;
        if (en)
        begin
            prod_next = PROD_W'(sum) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign quot = prod_reg[SHIFT +: srav_pkg::SAMPLE_W];

endmodule

`default_nettype wire

// File: design/supply_rail_average_monitor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-rail moving-average undervoltage monitor. Each request carries one sample per rail
// and yields one result: the truncated average of the last WINDOW_LEN samples of each rail
// and one undervoltage flag per rail. The first request after reset fills the whole window
// with its own samples. The block takes one request per cycle unless a stalled output
// backs up to the input, and has three register stages: a row of window cells with
// running sums, a registered reciprocal multiply for the divide, and the output register.
// A request passes through these stages in that order; a stalled output holds each stage
// in turn. Limits and enables must be written only while no request is in flight.

module supply_rail_average_monitor_top #(
    parameter int WINDOW_LEN = 10
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // main_sample, fan_sample, buck5_sample, buck7_sample, zero fill.
    input  wire logic [srav_pkg::TDATA_W-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // main_avg, fan_avg, buck5_avg, buck7_avg, main_low, fan_low, buck5_low, buck7_low.
    output logic [srav_pkg::TDATA_W-1:0]            m_axis_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [srav_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srav_pkg::SAMPLE_W-1:0]      cfg_data
);

    localparam int CLOG_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = srav_pkg::SAMPLE_W + CLOG_W;
    localparam int RAILS  = srav_pkg::RAILS;
    localparam int SW     = srav_pkg::SAMPLE_W;

    srav_pkg::sample_t limit_reg [RAILS];
    srav_pkg::sample_t limit_next [RAILS];
    logic buck5_on_reg;
    logic buck5_on_next;
    logic buck7_on_reg;
    logic buck7_on_next;

    logic primed_reg;
    logic primed_next;
    logic va_reg;
    logic va_next;
    logic vb_reg;
    logic vb_next;
    logic vc_reg;
    logic vc_next;
    logic [SUM_W-1:0] sum_reg [RAILS];
    logic [SUM_W-1:0] sum_next [RAILS];
    logic [srav_pkg::TDATA_W-1:0] out_reg;
    logic [srav_pkg::TDATA_W-1:0] out_next;

    logic en_a;
    logic en_b;
    logic en_c;
    logic accept;

    srav_pkg::rail_set_t  new_set;
    srav_pkg::rail_set_t  cell_q [WINDOW_LEN];
    srav_pkg::cell_ctrl_t ctrl;
    srav_pkg::sample_t    quot [RAILS];

    assign en_c          = !vc_reg || m_axis_tready;
    assign en_b          = !vb_reg || en_c;
    assign en_a          = !va_reg || en_b;
    assign s_axis_tready = en_a;
    assign accept        = s_axis_tvalid && en_a;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        for (int r = 0; r < RAILS; r++)
        begin
            new_set[r] = (s_axis_tdata[r*SW +: SW] > srav_pkg::SAMPLE_MAX) ?
                         srav_pkg::SAMPLE_MAX : s_axis_tdata[r*SW +: SW];
        end
    end

    assign ctrl.shift = accept;
    assign ctrl.fill  = !primed_reg;

    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        if (i == WINDOW_LEN - 1)
        begin : g_tail
            srav_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .fill_in  (new_set),
                .next_in  (new_set),
                .cell_out (cell_q[i])
            );
        end
        else
        begin : g_body
            srav_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .fill_in  (new_set),
                .next_in  (cell_q[i+1]),
                .cell_out (cell_q[i])
            );
        end
    end

    // Running sums: the oldest sample sits in the first cell.
    always_comb
    begin
        for (int r = 0; r < RAILS; r++)
        begin
            sum_next[r] = sum_reg[r];
            if (accept)
            begin
                if (!primed_reg)
                begin
                    sum_next[r] = SUM_W'(new_set[r]) * SUM_W'(WINDOW_LEN);
                end
                else
                begin
                    sum_next[r] = SUM_W'((SUM_W+1)'(sum_reg[r]) + (SUM_W+1)'(new_set[r])
                                         - (SUM_W+1)'(cell_q[0][r]));
                end
            end
        end
    end

    for (genvar r = 0; r < RAILS; r++)
    begin : g_div
        srav_div #(
            .WINDOW_LEN (WINDOW_LEN)
        ) u_div (
            .clk  (clk),
            .en   (en_b),
            .sum  (sum_reg[r]),
            .quot (quot[r])
        );
    end

    always_comb
    begin
        primed_next = primed_reg || accept;
        va_next     = en_a ? s_axis_tvalid : va_reg;
        vb_next     = en_b ? va_reg : vb_reg;
        vc_next     = en_c ? vb_reg : vc_reg;
        out_next    = out_reg;
        if (en_c && vb_reg)
        begin
            for (int r = 0; r < RAILS; r++)
            begin
                out_next[r*SW +: SW] = quot[r];
            end
            out_next[RAILS*SW + srav_pkg::RAIL_MAIN] =
                quot[srav_pkg::RAIL_MAIN] < limit_reg[srav_pkg::RAIL_MAIN];
            out_next[RAILS*SW + srav_pkg::RAIL_FAN] =
                quot[srav_pkg::RAIL_FAN] < limit_reg[srav_pkg::RAIL_FAN];
            out_next[RAILS*SW + srav_pkg::RAIL_BUCK5] = buck5_on_reg &&
                (quot[srav_pkg::RAIL_BUCK5] < limit_reg[srav_pkg::RAIL_BUCK5]);
            out_next[RAILS*SW + srav_pkg::RAIL_BUCK7] = buck7_on_reg &&
                (quot[srav_pkg::RAIL_BUCK7] < limit_reg[srav_pkg::RAIL_BUCK7]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < RAILS; r++)
        begin
            limit_next[r] = limit_reg[r];
        end
        buck5_on_next = buck5_on_reg;
        buck7_on_next = buck7_on_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                srav_pkg::REG_MAIN_LIMIT:  limit_next[srav_pkg::RAIL_MAIN]  = cfg_data;
                srav_pkg::REG_FAN_LIMIT:   limit_next[srav_pkg::RAIL_FAN]   = cfg_data;
                srav_pkg::REG_BUCK5_LIMIT: limit_next[srav_pkg::RAIL_BUCK5] = cfg_data;
                srav_pkg::REG_BUCK7_LIMIT: limit_next[srav_pkg::RAIL_BUCK7] = cfg_data;
                srav_pkg::REG_BUCK5_ON:    buck5_on_next = cfg_data[0];
                srav_pkg::REG_BUCK7_ON:    buck7_on_next = cfg_data[0];
                default:                   buck5_on_next = buck5_on_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RAILS; r++)
            begin
                limit_reg[r] <= srav_pkg::LIMIT_RESET[r];
            end
            buck5_on_reg <= 1'b0;
            buck7_on_reg <= 1'b0;
            primed_reg   <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < RAILS; r++)
            begin
                limit_reg[r] <= limit_next[r];
            end
            buck5_on_reg <= buck5_on_next;
            buck7_on_reg <= buck7_on_next;
            primed_reg   <= primed_next;
            va_reg       <= va_next;
            vb_reg       <= vb_next;
            vc_reg       <= vc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < RAILS; r++)
        begin
            sum_reg[r] <= sum_next[r];
        end
        out_reg <= out_next;
    end

    assign m_axis_tvalid = vc_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !va_reg |-> s_axis_tready)
        else $error("Input stalled while the first stage is empty.");

    a_stage_b_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && en_c) |=> m_axis_tvalid)
        else $error("A finished item did not reach the output register.");

    a_primed_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(primed_reg))
        else $error("Window fill state was lost without reset.");

    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |-> ((SUM_W+8)'(sum_reg[srav_pkg::RAIL_MAIN])
                        <= (SUM_W+8)'(srav_pkg::SAMPLE_MAX) * (SUM_W+8)'(WINDOW_LEN)))
        else $error("Running sum exceeds the largest possible window sum.");

    a_buck5_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[RAILS*SW + srav_pkg::RAIL_BUCK5]) |-> buck5_on_reg)
        else $error("5 V buck flag raised while the buck is disabled.");
`endif

endmodule

`default_nettype wire
